// ----- design/sha256sb_pkg.sv -----
// shared constants, types and round functions of the single-block sha-256 unit
`default_nettype none

package sha256sb_pkg;

  localparam logic [5:0] MaxBytes   = 6'd55;
  localparam logic [5:0] LastRound  = 6'd63;
  localparam logic [2:0] LastWord   = 3'd7;
  localparam logic [7:0] PadByte    = 8'h80;
  localparam int unsigned OutTdataW = 40;

  localparam logic [0:7][31:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StFold  = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // datapath commands from the sequencer
  typedef struct packed {
    logic wr_byte;
    logic pad;
    logic round;
    logic fold;
    logic shift_out;
    logic clear;
  } ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ----- design/sha256sb_core.sv -----
// message window, schedule and compression round datapath, one round per cycle
`default_nettype none

module sha256sb_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sha256sb_pkg::ctrl_t  ctrl_i,
  input  wire  [7:0]           byte_i,
  input  wire  [5:0]           cnt_i,
  input  wire  [5:0]           rnd_i,
  output logic [31:0]          word_o
);

  logic [31:0] w_q  [16];
  logic [31:0] w_d  [16];
  logic [31:0] st_q [8];
  logic [31:0] st_d [8];

  logic [4:0]  lane_bit;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // byte 0 of a word sits in its top lane
  assign lane_bit = {2'd3 - cnt_i[1:0], 3'b000};

  assign w_new = w_q[0] + sha256sb_pkg::small_sig0(w_q[1]) + w_q[9]
               + sha256sb_pkg::small_sig1(w_q[14]);

  assign ch  = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
  assign maj = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
  assign t1  = st_q[7] + sha256sb_pkg::big_sig1(st_q[4]) + ch
             + sha256sb_pkg::RoundK[rnd_i] + w_q[0];
  assign t2  = sha256sb_pkg::big_sig0(st_q[0]) + maj;

  always_comb begin
    w_d = w_q;
    if (ctrl_i.clear) begin
      for (int i = 0; i < 16; i++) begin
        w_d[i] = '0;
      end
    end else if (ctrl_i.wr_byte) begin
      w_d[cnt_i[5:2]][lane_bit +: 8] = byte_i;
    end else if (ctrl_i.pad) begin
      w_d[cnt_i[5:2]][lane_bit +: 8] = sha256sb_pkg::PadByte;
      w_d[15] = {23'd0, cnt_i, 3'b000};
    end else if (ctrl_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_new;
    end
  end

  always_comb begin
    st_d = st_q;
    if (ctrl_i.pad) begin
      for (int i = 0; i < 8; i++) begin
        st_d[i] = sha256sb_pkg::InitHash[i];
      end
    end else if (ctrl_i.round) begin
      st_d[7] = st_q[6];
      st_d[6] = st_q[5];
      st_d[5] = st_q[4];
      st_d[4] = st_q[3] + t1;
      st_d[3] = st_q[2];
      st_d[2] = st_q[1];
      st_d[1] = st_q[0];
      st_d[0] = t1 + t2;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        st_d[i] = st_q[i] + sha256sb_pkg::InitHash[i];
      end
    end else if (ctrl_i.shift_out) begin
      for (int i = 0; i < 7; i++) begin
        st_d[i] = st_q[i+1];
      end
      st_d[7] = '0;
    end
  end

  // window must start at zero, so it is reset and cleared after each message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign word_o = st_q[0];

endmodule

`default_nettype wire

// ----- design/sha256_single_block_hash_unit.sv -----
// top level: byte collector, round sequencer and digest output of the sha-256 unit
//
//  channel   dir  tdata                                       tuser         tlast
//  s_axis    in   [7:0] data_byte                             has_byte      last
//  m_axis    out  [31:0] digest_word, [34:32] word_index      length_error  last_word
//
// one byte is taken per cycle while collecting; a tlast request of a message that fits
// goes through a pad step, the compression rounds of the round unit and a fold step, then
// 8 digest words leave one per cycle when m_axis_tready_i is high; an overflowed
// message goes straight to its single error word in the next cycle.
// input is not ready from the tlast request until the final word is taken.
// output stalls hold the word in place; reset clears the buffer, count and flags.
`default_nettype none

module sha256_single_block_hash_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire         s_axis_tuser_i,   // [0] has_byte
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [sha256sb_pkg::OutTdataW-1:0] m_axis_tdata_o,  // [31:0] digest_word,
                                                             // [34:32] word_index
  output logic        m_axis_tuser_o,   // [0] length_error
  output logic        m_axis_tlast_o
);

  sha256sb_pkg::state_e state_q, state_d;
  sha256sb_pkg::ctrl_t  ctrl;

  logic [5:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  widx_q, widx_d;
  logic        err_q, err_d;
  logic [31:0] word;
  logic        in_acc;
  logic        out_acc;
  logic        room;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign room    = (cnt_q != sha256sb_pkg::MaxBytes);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    err_d   = err_q;
    ctrl    = '0;
    unique case (state_q)
      sha256sb_pkg::StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            if (room) begin
              ctrl.wr_byte = 1'b1;
              cnt_d        = cnt_q + 6'd1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (s_axis_tlast_i) begin
            widx_d = '0;
            rnd_d  = '0;
            if (ovf_d) begin
              err_d   = 1'b1;
              state_d = sha256sb_pkg::StOut;
            end else begin
              state_d = sha256sb_pkg::StPad;
            end
          end
        end
      end
      sha256sb_pkg::StPad: begin
        ctrl.pad = 1'b1;
        state_d  = sha256sb_pkg::StRound;
      end
      sha256sb_pkg::StRound: begin
        ctrl.round = 1'b1;
        rnd_d      = rnd_q + 6'd1;
        if (rnd_q == sha256sb_pkg::LastRound) begin
          state_d = sha256sb_pkg::StFold;
        end
      end
      sha256sb_pkg::StFold: begin
        ctrl.fold = 1'b1;
        state_d   = sha256sb_pkg::StOut;
      end
      sha256sb_pkg::StOut: begin
        if (out_acc) begin
          if (err_q || widx_q == sha256sb_pkg::LastWord) begin
            ctrl.clear = 1'b1;
            cnt_d      = '0;
            ovf_d      = 1'b0;
            err_d      = 1'b0;
            widx_d     = '0;
            state_d    = sha256sb_pkg::StIdle;
          end else begin
            ctrl.shift_out = 1'b1;
            widx_d         = widx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = sha256sb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256sb_pkg::StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      rnd_q   <= '0;
      widx_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      err_q   <= err_d;
    end
  end

  sha256sb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .byte_i (s_axis_tdata_i),
    .cnt_i  (cnt_q),
    .rnd_i  (rnd_q),
    .word_o (word)
  );

  assign s_axis_tready_o = (state_q == sha256sb_pkg::StIdle);
  assign m_axis_tvalid_o = (state_q == sha256sb_pkg::StOut);
  assign m_axis_tdata_o  = {5'd0, widx_q, (err_q ? 32'd0 : word)};
  assign m_axis_tuser_o  = err_q;
  assign m_axis_tlast_o  = err_q | (widx_q == sha256sb_pkg::LastWord);

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sha256sb_pkg::MaxBytes)
    else $error("byte count beyond limit");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && widx_q == 3'd0))
    else $error("error result not a single last word");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256sb_pkg::StRound && rnd_q == sha256sb_pkg::LastRound)
      |=> state_q == sha256sb_pkg::StFold)
    else $error("round count did not end in fold");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (cnt_q == 6'd0 && !ovf_q && s_axis_tready_o))
    else $error("message state not cleared after last word");

endmodule

`default_nettype wire

// ----- tb/tb_sha256_single_block_hash_unit.sv -----
// testbench for the single-block sha-256 unit: byte requests in, predicted digest words checked out
`timescale 1ns / 1ps

module tb_sha256_single_block_hash_unit;

  localparam int unsigned MsgCap     = 55;
  localparam int unsigned TailCycles = 100;

  localparam logic [0:7][31:0] ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ShaK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
    logic        length_error;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // predictor state: collected bytes, their count and the overflow mark
  logic [7:0]   msg_bytes [64];
  int unsigned  msg_len = 0;
  logic         msg_overflow = 1'b0;
  digest_word_t digest_q [$];
  logic [7:0]   outgoing_msg [$];
  int unsigned  mismatch_count = 0;
  logic         quiet_tail = 1'b0;

  sha256_single_block_hash_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // one compression of the padded block built from the collected bytes
  function automatic logic [0:7][31:0] sha256_digest(input int unsigned len);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] bits, s0, s1, t1, t2;
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [0:7][31:0] dg;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg_bytes[i] : 8'h00;
    blk[len] = 8'h80;
    bits = len * 8;
    blk[60] = bits[31:24];
    blk[61] = bits[23:16];
    blk[62] = bits[15:8];
    blk[63] = bits[7:0];
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = ShaIv;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) + ShaK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    dg[0] = a + ShaIv[0]; dg[1] = b + ShaIv[1]; dg[2] = c + ShaIv[2]; dg[3] = d + ShaIv[3];
    dg[4] = e + ShaIv[4]; dg[5] = f + ShaIv[5]; dg[6] = g + ShaIv[6]; dg[7] = h + ShaIv[7];
    return dg;
  endfunction

  function automatic void predict_request(input logic [7:0] data, input logic has,
                                          input logic fin);
    logic [0:7][31:0] dg;
    digest_word_t dw;
    if (has) begin
      if (msg_len < MsgCap) begin
        msg_bytes[msg_len] = data;
        msg_len++;
      end else begin
        msg_overflow = 1'b1;
      end
    end
    if (fin) begin
      if (msg_overflow) begin
        dw = '{word: 32'h0, index: 3'd0, last_word: 1'b1, length_error: 1'b1};
        digest_q.push_back(dw);
      end else begin
        dg = sha256_digest(msg_len);
        for (int k = 0; k < 8; k++) begin
          dw = '{word: dg[k], index: 3'(k), last_word: (k == 7), length_error: 1'b0};
          digest_q.push_back(dw);
        end
      end
      msg_len = 0;
      msg_overflow = 1'b0;
    end
  endfunction

  // one request; valid stays up afterwards so back-to-back requests need one assignment
  task automatic send_request(input logic [7:0] data, input logic has, input logic fin);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(data, has, fin);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // sends outgoing_msg; an empty tail or an empty message closes with a byteless last request
  task automatic send_message(input logic empty_tail, input logic noise);
    int unsigned n;
    n = outgoing_msg.size();
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 3) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(outgoing_msg[i], 1'b1, (i == n - 1) && !empty_tail);
    end
    if (empty_tail || n == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic fill_random(input int unsigned n);
    outgoing_msg.delete();
    for (int i = 0; i < n; i++) outgoing_msg.push_back(8'($urandom));
  endtask

  task automatic wait_for_digests();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // empty message
    outgoing_msg.delete();
    send_message(1'b0, 1'b0);
    outgoing_msg = '{8'h00};
    send_message(1'b0, 1'b0);
    outgoing_msg = '{8'hff};
    send_message(1'b0, 1'b0);
    outgoing_msg = '{8'h61, 8'h62, 8'h63};
    send_message(1'b0, 1'b0);
    // byteless requests inside a message and a byteless close
    outgoing_msg = '{8'hff, 8'h00, 8'h5a, 8'ha5};
    send_message(1'b1, 1'b1);
  endtask

  task automatic test_length_limit();
    // longest message that still fits, closed by its last byte and by a byteless last
    fill_random(MsgCap);
    send_message(1'b0, 1'b0);
    fill_random(MsgCap);
    send_message(1'b1, 1'b0);
    // one byte too many, and far too many with a byteless close
    fill_random(MsgCap + 1);
    send_message(1'b0, 1'b0);
    fill_random(64 + 6);
    send_message(1'b1, 1'b1);
    // message right after an error starts from an empty buffer
    outgoing_msg = '{8'h61, 8'h62, 8'h63};
    send_message(1'b0, 1'b0);
  endtask

  task automatic test_drain_pause();
    fill_random(7);
    send_message(1'b0, 1'b0);
    stop_sending();
    wait_for_digests();
    fill_random(2);
    send_message(1'b0, 1'b0);
  endtask

  task automatic test_random(input int unsigned n_bytes);
    int unsigned sent, len, pick;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(MsgCap + 1, 70);
      else if (pick == 1) len = $urandom_range(30, MsgCap);
      else len = $urandom_range(0, 12);
      fill_random(len);
      send_message($urandom_range(0, 4) == 0, $urandom_range(0, 5) == 0);
      sent += len;
    end
  endtask

  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    for (int m = 0; m < 2; m++) begin
      fill_random($urandom_range(0, 20));
      send_message(1'b0, 1'b0);
    end
    fill_random(MsgCap + 1);
    send_message(1'b0, 1'b0);
  endtask

  // receiver: random stall bursts, always ready in the last part
  always begin
    @(posedge clk_i);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  end

  always @(posedge clk_i) begin
    digest_word_t dw;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual data %h user %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        dw = digest_q.pop_front();
        if (m_axis_tdata[31:0] !== dw.word) begin
          $display("%0t digest_word mismatch: expected %h actual %h",
                   $time, dw.word, m_axis_tdata[31:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[34:32] !== dw.index) begin
          $display("%0t word_index mismatch: expected %0d actual %0d",
                   $time, dw.index, m_axis_tdata[34:32]);
          mismatch_count++;
        end
        if (m_axis_tlast !== dw.last_word) begin
          $display("%0t last_word mismatch: expected %b actual %b",
                   $time, dw.last_word, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser !== dw.length_error) begin
          $display("%0t length_error mismatch: expected %b actual %b",
                   $time, dw.length_error, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[39:35] !== 5'b0) begin
          $display("%0t tdata padding mismatch: expected %h actual %h",
                   $time, 5'b0, m_axis_tdata[39:35]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_length_limit();
    test_drain_pause();
    test_random(60);
    test_quiet_tail();
    stop_sending();
    wait_for_digests();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
